// File: hw/rtl/c8ie_pkg.sv
`timescale 1ns / 1ps

package c8ie_pkg;

  typedef logic [5:0] op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  operand;
    logic [15:0] target_addr;
    logic [15:0] next_pc;
    logic [7:0]  pull_lo;
    logic [7:0]  pull_hi;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        jump_valid;
    logic [15:0] jump_addr;
    logic [1:0]  extra_cycles;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic        last;
  } out_item_t;

  // status bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] PUSH_BITS  = 8'h30;
  localparam logic [7:0] SP_RESET   = 8'hFD;
  localparam logic [7:0] P_RESET    = 8'h24;

  localparam op_t OP_ADC   = 6'd0;
  localparam op_t OP_AND   = 6'd1;
  localparam op_t OP_ASL   = 6'd2;
  localparam op_t OP_ASL_A = 6'd3;
  localparam op_t OP_BIT   = 6'd4;
  localparam op_t OP_BPL   = 6'd5;
  localparam op_t OP_BMI   = 6'd6;
  localparam op_t OP_BVC   = 6'd7;
  localparam op_t OP_BVS   = 6'd8;
  localparam op_t OP_BCC   = 6'd9;
  localparam op_t OP_BCS   = 6'd10;
  localparam op_t OP_BNE   = 6'd11;
  localparam op_t OP_BEQ   = 6'd12;
  localparam op_t OP_DEC   = 6'd13;
  localparam op_t OP_EOR   = 6'd14;
  localparam op_t OP_CLC   = 6'd15;
  localparam op_t OP_SEC   = 6'd16;
  localparam op_t OP_CLI   = 6'd17;
  localparam op_t OP_SEI   = 6'd18;
  localparam op_t OP_CLV   = 6'd19;
  localparam op_t OP_CLD   = 6'd20;
  localparam op_t OP_SED   = 6'd21;
  localparam op_t OP_INC   = 6'd22;
  localparam op_t OP_JMP   = 6'd23;
  localparam op_t OP_JSR   = 6'd24;
  localparam op_t OP_LDA   = 6'd25;
  localparam op_t OP_LDX   = 6'd26;
  localparam op_t OP_LDY   = 6'd27;
  localparam op_t OP_LSR   = 6'd28;
  localparam op_t OP_LSR_A = 6'd29;
  localparam op_t OP_NOP   = 6'd30;
  localparam op_t OP_ORA   = 6'd31;
  localparam op_t OP_TAX   = 6'd32;
  localparam op_t OP_TXA   = 6'd33;
  localparam op_t OP_DEX   = 6'd34;
  localparam op_t OP_INX   = 6'd35;
  localparam op_t OP_TAY   = 6'd36;
  localparam op_t OP_TYA   = 6'd37;
  localparam op_t OP_DEY   = 6'd38;
  localparam op_t OP_INY   = 6'd39;
  localparam op_t OP_ROL   = 6'd40;
  localparam op_t OP_ROL_A = 6'd41;
  localparam op_t OP_ROR   = 6'd42;
  localparam op_t OP_ROR_A = 6'd43;
  localparam op_t OP_RTS   = 6'd44;
  localparam op_t OP_SBC   = 6'd45;
  localparam op_t OP_STA   = 6'd46;
  localparam op_t OP_TXS   = 6'd47;
  localparam op_t OP_TSX   = 6'd48;
  localparam op_t OP_PHA   = 6'd49;
  localparam op_t OP_PLA   = 6'd50;
  localparam op_t OP_PHP   = 6'd51;
  localparam op_t OP_PLP   = 6'd52;
  localparam op_t OP_STX   = 6'd53;
  localparam op_t OP_STY   = 6'd54;

endpackage

// File: hw/rtl/c8ie_chan_if.sv
`timescale 1ns / 1ps

interface c8ie_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// File: hw/rtl/cpu_8bit_instruction_execute.sv
`timescale 1ns / 1ps
// result path: a result is written into the result queue when its request is accepted and offered from its head
// throughput: one request per cycle; jsr fills two output beats
// rate set by the three-entry result queue: requests are taken while it holds at most one
// reset: a, x, y cleared, sp = 0xfd, p = 0x24, result queue emptied
module cpu_8bit_instruction_execute (
  input  logic         clk,
  input  logic         rst,
  c8ie_chan_if.sink    in_ch,
  c8ie_chan_if.source  out_ch
);

  localparam int QDEPTH = 3;

  logic [7:0] acc, acc_next;
  logic [7:0] x_idx, x_idx_next;
  logic [7:0] y_idx, y_idx_next;
  logic [7:0] sp, sp_next;
  logic [7:0] status, status_next;

  c8ie_pkg::out_item_t queue [QDEPTH];
  logic [1:0] head, head_next;
  logic [1:0] count, count_next;
  logic [1:0] tail0, tail1;

  c8ie_pkg::in_item_t  req;
  c8ie_pkg::out_item_t res0, res1;
  logic        two;
  logic        accept, pop;

  logic        wv, jv, cond;
  logic [15:0] wa, ja;
  logic [7:0]  wd, m, v, add_m;
  logic [8:0]  sum;
  logic [1:0]  extra;
  logic        c_in;

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] val);
    logic [7:0] r;
    r = p;
    r[c8ie_pkg::FLAG_N] = val[7];
    r[c8ie_pkg::FLAG_Z] = (val == 8'd0);
    return r;
  endfunction

  function automatic logic [1:0] wrap3(input logic [2:0] s);
    logic [2:0] r;
    r = (s >= 3'(QDEPTH)) ? s - 3'(QDEPTH) : s;
    return r[1:0];
  endfunction

  assign req    = in_ch.payload;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  assign in_ch.ready    = (count <= 2'd1);
  assign out_ch.valid   = (count != 2'd0);
  assign out_ch.payload = queue[head];

  assign m     = req.operand;
  assign c_in  = status[c8ie_pkg::FLAG_C];
  assign add_m = (req.op == c8ie_pkg::OP_SBC) ? ~m : m;
  assign sum   = {1'b0, acc} + {1'b0, add_m} + {8'd0, c_in};

  always_comb begin
    acc_next    = acc;
    x_idx_next  = x_idx;
    y_idx_next  = y_idx;
    sp_next     = sp;
    status_next = status;
    wv = 1'b0;
    wa = 16'd0;
    wd = 8'd0;
    jv = 1'b0;
    ja = 16'd0;
    cond = 1'b0;
    two = 1'b0;
    v = 8'd0;
    unique case (req.op) inside
      c8ie_pkg::OP_ADC, c8ie_pkg::OP_SBC: begin
        acc_next = sum[7:0];
        status_next = nz(status, sum[7:0]);
        status_next[c8ie_pkg::FLAG_C] = sum[8];
        status_next[c8ie_pkg::FLAG_V] = ~(acc[7] ^ add_m[7]) & (acc[7] ^ sum[7]);
      end
      c8ie_pkg::OP_AND: begin
        acc_next = acc & m;
        status_next = nz(status, acc & m);
      end
      c8ie_pkg::OP_EOR: begin
        acc_next = acc ^ m;
        status_next = nz(status, acc ^ m);
      end
      c8ie_pkg::OP_ORA: begin
        acc_next = acc | m;
        status_next = nz(status, acc | m);
      end
      c8ie_pkg::OP_ASL, c8ie_pkg::OP_LSR, c8ie_pkg::OP_ROL, c8ie_pkg::OP_ROR,
      c8ie_pkg::OP_DEC, c8ie_pkg::OP_INC: begin
        case (req.op)
          c8ie_pkg::OP_ASL: v = {m[6:0], 1'b0};
          c8ie_pkg::OP_LSR: v = {1'b0, m[7:1]};
          c8ie_pkg::OP_ROL: v = {m[6:0], c_in};
          c8ie_pkg::OP_ROR: v = {c_in, m[7:1]};
          c8ie_pkg::OP_DEC: v = m - 8'd1;
          default:          v = m + 8'd1;
        endcase
        status_next = nz(status, v);
        if (req.op == c8ie_pkg::OP_ASL || req.op == c8ie_pkg::OP_ROL) begin
          status_next[c8ie_pkg::FLAG_C] = m[7];
        end else if (req.op == c8ie_pkg::OP_LSR || req.op == c8ie_pkg::OP_ROR) begin
          status_next[c8ie_pkg::FLAG_C] = m[0];
        end
        wv = 1'b1;
        wa = req.target_addr;
        wd = v;
      end
      c8ie_pkg::OP_ASL_A, c8ie_pkg::OP_LSR_A, c8ie_pkg::OP_ROL_A, c8ie_pkg::OP_ROR_A: begin
        case (req.op)
          c8ie_pkg::OP_ASL_A: v = {acc[6:0], 1'b0};
          c8ie_pkg::OP_LSR_A: v = {1'b0, acc[7:1]};
          c8ie_pkg::OP_ROL_A: v = {acc[6:0], c_in};
          default:            v = {c_in, acc[7:1]};
        endcase
        acc_next = v;
        status_next = nz(status, v);
        if (req.op == c8ie_pkg::OP_ASL_A || req.op == c8ie_pkg::OP_ROL_A) begin
          status_next[c8ie_pkg::FLAG_C] = acc[7];
        end else begin
          status_next[c8ie_pkg::FLAG_C] = acc[0];
        end
      end
      c8ie_pkg::OP_BIT: begin
        status_next[c8ie_pkg::FLAG_N] = m[7];
        status_next[c8ie_pkg::FLAG_V] = m[6];
        status_next[c8ie_pkg::FLAG_Z] = ((m & acc) == 8'd0);
      end
      c8ie_pkg::OP_BPL: cond = ~status[c8ie_pkg::FLAG_N];
      c8ie_pkg::OP_BMI: cond = status[c8ie_pkg::FLAG_N];
      c8ie_pkg::OP_BVC: cond = ~status[c8ie_pkg::FLAG_V];
      c8ie_pkg::OP_BVS: cond = status[c8ie_pkg::FLAG_V];
      c8ie_pkg::OP_BCC: cond = ~status[c8ie_pkg::FLAG_C];
      c8ie_pkg::OP_BCS: cond = status[c8ie_pkg::FLAG_C];
      c8ie_pkg::OP_BNE: cond = ~status[c8ie_pkg::FLAG_Z];
      c8ie_pkg::OP_BEQ: cond = status[c8ie_pkg::FLAG_Z];
      c8ie_pkg::OP_CLC: status_next[c8ie_pkg::FLAG_C] = 1'b0;
      c8ie_pkg::OP_SEC: status_next[c8ie_pkg::FLAG_C] = 1'b1;
      c8ie_pkg::OP_CLI: status_next[c8ie_pkg::FLAG_I] = 1'b0;
      c8ie_pkg::OP_SEI: status_next[c8ie_pkg::FLAG_I] = 1'b1;
      c8ie_pkg::OP_CLV: status_next[c8ie_pkg::FLAG_V] = 1'b0;
      c8ie_pkg::OP_CLD: status_next[c8ie_pkg::FLAG_D] = 1'b0;
      c8ie_pkg::OP_SED: status_next[c8ie_pkg::FLAG_D] = 1'b1;
      c8ie_pkg::OP_JMP: begin
        jv = 1'b1;
        ja = req.target_addr;
      end
      c8ie_pkg::OP_JSR: begin
        two = 1'b1;
        sp_next = sp - 8'd2;
      end
      c8ie_pkg::OP_LDA: begin
        acc_next = m;
        status_next = nz(status, m);
      end
      c8ie_pkg::OP_LDX: begin
        x_idx_next = m;
        status_next = nz(status, m);
      end
      c8ie_pkg::OP_LDY: begin
        y_idx_next = m;
        status_next = nz(status, m);
      end
      c8ie_pkg::OP_TAX: begin
        x_idx_next = acc;
        status_next = nz(status, acc);
      end
      c8ie_pkg::OP_TXA: begin
        acc_next = x_idx;
        status_next = nz(status, x_idx);
      end
      c8ie_pkg::OP_DEX: begin
        x_idx_next = x_idx - 8'd1;
        status_next = nz(status, x_idx - 8'd1);
      end
      c8ie_pkg::OP_INX: begin
        x_idx_next = x_idx + 8'd1;
        status_next = nz(status, x_idx + 8'd1);
      end
      c8ie_pkg::OP_TAY: begin
        y_idx_next = acc;
        status_next = nz(status, acc);
      end
      c8ie_pkg::OP_TYA: begin
        acc_next = y_idx;
        status_next = nz(status, y_idx);
      end
      c8ie_pkg::OP_DEY: begin
        y_idx_next = y_idx - 8'd1;
        status_next = nz(status, y_idx - 8'd1);
      end
      c8ie_pkg::OP_INY: begin
        y_idx_next = y_idx + 8'd1;
        status_next = nz(status, y_idx + 8'd1);
      end
      c8ie_pkg::OP_RTS: begin
        sp_next = sp + 8'd2;
        jv = 1'b1;
        ja = {req.pull_hi, req.pull_lo};
      end
      c8ie_pkg::OP_STA: begin
        wv = 1'b1;
        wa = req.target_addr;
        wd = acc;
      end
      c8ie_pkg::OP_STX: begin
        wv = 1'b1;
        wa = req.target_addr;
        wd = x_idx;
      end
      c8ie_pkg::OP_STY: begin
        wv = 1'b1;
        wa = req.target_addr;
        wd = y_idx;
      end
      c8ie_pkg::OP_TXS: sp_next = x_idx;
      c8ie_pkg::OP_TSX: begin
        x_idx_next = sp;
        status_next = nz(status, sp);
      end
      c8ie_pkg::OP_PHA: begin
        wv = 1'b1;
        wa = {c8ie_pkg::STACK_PAGE, sp};
        wd = acc;
        sp_next = sp - 8'd1;
      end
      c8ie_pkg::OP_PHP: begin
        wv = 1'b1;
        wa = {c8ie_pkg::STACK_PAGE, sp};
        wd = status | c8ie_pkg::PUSH_BITS;
        sp_next = sp - 8'd1;
      end
      c8ie_pkg::OP_PLA: begin
        sp_next = sp + 8'd1;
        acc_next = req.pull_lo;
        status_next = nz(status, req.pull_lo);
      end
      c8ie_pkg::OP_PLP: begin
        sp_next = sp + 8'd1;
        status_next = req.pull_lo;
      end
      default: begin
      end
    endcase
    if (cond) begin
      jv = 1'b1;
      ja = req.target_addr;
    end
  end

  // a taken branch that crosses a page gets a larger extra_cycles value than one that does not
  assign extra = !cond ? 2'd0 :
                 (req.next_pc[15:8] != req.target_addr[15:8]) ? 2'd2 : 2'd1;

  always_comb begin
    res0.acc_out    = acc_next;
    res0.x_out      = x_idx_next;
    res0.y_out      = y_idx_next;
    res0.sp_out     = sp_next;
    res0.status_out = status_next;
    res1.acc_out    = acc_next;
    res1.x_out      = x_idx_next;
    res1.y_out      = y_idx_next;
    res1.sp_out     = sp_next;
    res1.status_out = status_next;
    if (two) begin
      // jsr: high byte first, then low byte with the redirect
      res0.write_valid  = 1'b1;
      res0.write_addr   = {c8ie_pkg::STACK_PAGE, sp};
      res0.write_data   = req.next_pc[15:8];
      res0.jump_valid   = 1'b0;
      res0.jump_addr    = 16'd0;
      res0.extra_cycles = 2'd0;
      res0.last         = 1'b0;
      res1.write_valid  = 1'b1;
      res1.write_addr   = {c8ie_pkg::STACK_PAGE, sp - 8'd1};
      res1.write_data   = req.next_pc[7:0];
      res1.jump_valid   = 1'b1;
      res1.jump_addr    = req.target_addr;
      res1.extra_cycles = 2'd0;
      res1.last         = 1'b1;
    end else begin
      res0.write_valid  = wv;
      res0.write_addr   = wa;
      res0.write_data   = wd;
      res0.jump_valid   = jv;
      res0.jump_addr    = ja;
      res0.extra_cycles = extra;
      res0.last         = 1'b1;
      res1 = res0;
    end
  end

  assign tail0 = wrap3({1'b0, head} + {1'b0, count});
  assign tail1 = wrap3({1'b0, tail0} + 3'd1);

  always_comb begin
    logic [2:0] cnt;
    cnt = {1'b0, count};
    if (accept) begin
      cnt = cnt + (two ? 3'd2 : 3'd1);
    end
    if (pop) begin
      cnt = cnt - 3'd1;
    end
    count_next = cnt[1:0];
    head_next  = pop ? wrap3({1'b0, head} + 3'd1) : head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 8'd0;
      x_idx  <= 8'd0;
      y_idx  <= 8'd0;
      sp     <= c8ie_pkg::SP_RESET;
      status <= c8ie_pkg::P_RESET;
      head   <= 2'd0;
      count  <= 2'd0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (accept) begin
        acc    <= acc_next;
        x_idx  <= x_idx_next;
        y_idx  <= y_idx_next;
        sp     <= sp_next;
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[tail0] <= res0;
      if (two) begin
        queue[tail1] <= res1;
      end
    end
  end

endmodule
